[hdl/mts_pkg.sv]
// Shared types, codes and the melody note ROM for the melody tone sequencer.
package mts_pkg;

  localparam int FUNC_W      = 2;
  localparam int SEL_W       = 3;
  localparam int PLAY_TIME_W = 20;
  localparam int FREQ_W      = 11;
  localparam int LEN_W       = 9;
  localparam int MEL_W       = 2;
  localparam int POS_W       = 3;
  localparam int CNT_W       = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [MEL_W-1:0] {
    MEL_NORMAL    = 2'd0,
    MEL_INTERVAL  = 2'd1,
    MEL_EMERGENCY = 2'd2,
    MEL_SPECIAL   = 2'd3
  } melody_t;

  // Number of notes stored for each melody.
  function automatic logic [CNT_W-1:0] mel_count(input melody_t m);
    case (m)
      MEL_NORMAL:    mel_count = 5'd5;
      MEL_INTERVAL:  mel_count = 5'd3;
      MEL_EMERGENCY: mel_count = 5'd7;
      MEL_SPECIAL:   mel_count = 5'd4;
      default:       mel_count = 5'd5;
    endcase
  endfunction

  // Note frequency in Hz; unused slots read as silence.
  function automatic logic [FREQ_W-1:0] note_freq(input melody_t m,
                                                  input logic [POS_W-1:0] p);
    note_freq = '0;
    case (m)
      MEL_NORMAL:    if (p <= 3'd4 && !p[0]) note_freq = 11'd1000;
      MEL_INTERVAL:  if (p == 3'd0 || p == 3'd2) note_freq = 11'd800;
      MEL_EMERGENCY: if (p <= 3'd6 && !p[0]) note_freq = 11'd1500;
      MEL_SPECIAL: begin
        case (p)
          3'd0:    note_freq = 11'd600;
          3'd1:    note_freq = 11'd800;
          3'd2:    note_freq = 11'd1000;
          3'd3:    note_freq = 11'd1200;
          default: note_freq = '0;
        endcase
      end
      default:       note_freq = '0;
    endcase
  endfunction

  // Note length in milliseconds; unused slots read as zero.
  function automatic logic [LEN_W-1:0] note_len(input melody_t m,
                                                input logic [POS_W-1:0] p);
    note_len = '0;
    case (m)
      MEL_NORMAL:    if (p <= 3'd4) note_len = p[0] ? 9'd100 : 9'd200;
      MEL_INTERVAL:  if (p <= 3'd2) note_len = p[0] ? 9'd200 : 9'd500;
      MEL_EMERGENCY: if (p <= 3'd6) note_len = p[0] ? 9'd50 : 9'd100;
      MEL_SPECIAL: begin
        if (p <= 3'd2) note_len = 9'd200;
        else if (p == 3'd3) note_len = 9'd400;
      end
      default:       note_len = '0;
    endcase
  endfunction

endpackage

[hdl/melody_tone_sequencer.sv]
// Top level of the melody tone sequencer: state memory, note update and result register.
//
// Usage: each input beat (in_func) is a one millisecond tick, a start with a
// melody number and a play time, a stop request or no operation. Every input beat yields
// exactly one result beat with the tone frequency, the tone enable and the
// busy flag as they stand after that beat was handled.
// Both channels use valid/stall; a beat moves when valid is high and stall is
// low. A taken beat waits in the input stage register and then moves to the
// output register: the state memory is read at the edge that takes the beat,
// and the updated state and tone are registered as the beat leaves that stage.
// Throughput is one beat per cycle while the receiver does not stall: the
// sequencer state lives in a one-entry synchronous memory read every cycle,
// and the last written state is forwarded so beats may follow back to back.
// When the receiver stalls, the output register holds its beat and the
// input stalls as soon as the internal stage is also full.
// Reset clears the pipeline valids and marks the state memory as not yet
// written, so the block starts idle and silent.
module melody_tone_sequencer
  import mts_pkg::*;
#(
  parameter int MAX_NOTES = 8,
  parameter int TIME_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [SEL_W-1:0]       in_melody_sel,
  input  logic [PLAY_TIME_W-1:0] in_play_time_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FREQ_W-1:0]      out_tone_freq_hz,
  output logic                   out_tone_on,
  output logic                   out_busy_res
);

  localparam int PT_W  = (TIME_BITS < PLAY_TIME_W) ? TIME_BITS : PLAY_TIME_W;
  localparam int ACC_W = TIME_BITS + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NOTES);

  typedef struct packed {
    logic                 playing;
    logic                 stop_pending;
    melody_t              active_melody;
    logic [POS_W-1:0]     note_pos;
    logic [LEN_W-1:0]     note_left_ms;
    logic [ACC_W-1:0]     played_ms;
    logic [TIME_BITS-1:0] target_ms;
  } state_t;

  state_t state_mem [1];
  state_t rd_r;
  state_t fwd_r;
  logic   fwd_vld_r;
  logic   mem_init_r;

  logic                   s1_vld_r;
  logic [FUNC_W-1:0]      s1_func_r;
  logic [SEL_W-1:0]       s1_sel_r;
  logic [PLAY_TIME_W-1:0] s1_time_r;

  logic              out_vld_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic              out_on_r;
  logic              out_busy_r;

  logic              s1_adv;
  logic              in_take;
  state_t            st;
  state_t            st_nxt;
  logic [CNT_W-1:0]  mel_len;
  logic [CNT_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  left_dec;
  logic [ACC_W-1:0]  played_sum;
  logic [FREQ_W-1:0] freq_nxt;

  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // A write lands in the memory at the same edge as the read, so the most recently
  // written state, not yet in the read register, comes from the forwarding register.
  always_comb begin
    if (fwd_vld_r) st = fwd_r;
    else if (mem_init_r) st = rd_r;
    else st = '0;
  end

  always_comb begin
    mel_len    = (mel_count(st.active_melody) > MAX_CNT) ? MAX_CNT
                                                         : mel_count(st.active_melody);
    pos_inc    = CNT_W'(st.note_pos) + CNT_W'(1);
    left_dec   = (st.note_left_ms != '0) ? st.note_left_ms - LEN_W'(1) : st.note_left_ms;
    played_sum = st.played_ms + ACC_W'(note_len(st.active_melody, st.note_pos));
    st_nxt     = st;
    case (func_t'(s1_func_r))
      FUNC_START: begin
        if (!st.playing) begin
          st_nxt.stop_pending = 1'b0;
          if (s1_time_r[PT_W-1:0] != '0) begin
            st_nxt.playing       = 1'b1;
            st_nxt.active_melody = (s1_sel_r > SEL_W'(3)) ? MEL_NORMAL
                                                          : melody_t'(s1_sel_r[MEL_W-1:0]);
            st_nxt.note_pos      = '0;
            st_nxt.note_left_ms  = note_len(st_nxt.active_melody, '0);
            st_nxt.played_ms     = '0;
            st_nxt.target_ms     = TIME_BITS'(s1_time_r[PT_W-1:0]);
          end
        end
      end
      FUNC_STOP: st_nxt.stop_pending = 1'b1;
      FUNC_TICK: begin
        if (st.playing) begin
          st_nxt.note_left_ms = left_dec;
          if (left_dec == '0) begin
            st_nxt.played_ms = played_sum;
            st_nxt.note_pos  = (pos_inc >= mel_len) ? '0 : pos_inc[POS_W-1:0];
            if (st.stop_pending || played_sum >= ACC_W'(st.target_ms)) begin
              st_nxt.playing      = 1'b0;
              st_nxt.note_left_ms = '0;
            end else begin
              st_nxt.note_left_ms = note_len(st.active_melody, st_nxt.note_pos);
            end
          end
        end
      end
      default: st_nxt = st;
    endcase
    freq_nxt = st_nxt.playing ? note_freq(st_nxt.active_melody, st_nxt.note_pos) : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      state_mem[0] <= st_nxt;
    end
    rd_r <= state_mem[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r  <= 1'b0;
      mem_init_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      fwd_vld_r <= s1_adv;
      if (s1_adv) mem_init_r <= 1'b1;
      if (in_take) s1_vld_r <= 1'b1;
      else if (s1_adv) s1_vld_r <= 1'b0;
      if (s1_adv) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_r      <= st_nxt;
      out_freq_r <= freq_nxt;
      out_on_r   <= (freq_nxt != '0);
      out_busy_r <= st_nxt.playing;
    end
    if (in_take) begin
      s1_func_r <= in_func;
      s1_sel_r  <= in_melody_sel;
      s1_time_r <= in_play_time_ms;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_tone_freq_hz = out_freq_r;
  assign out_tone_on      = out_on_r;
  assign out_busy_res     = out_busy_r;

endmodule

[hdl/mts_checker.sv]
// Port-level checker for the melody tone sequencer and its bind.
module mts_checker
  import mts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [FREQ_W-1:0] out_tone_freq_hz,
  input logic              out_tone_on,
  input logic              out_busy_res
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tone_freq_hz) &&
      $stable(out_tone_on) && $stable(out_busy_res))
    else $error("stalled result beat changed");

  // An idle result is always silent.
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_tone_freq_hz == '0 && !out_tone_on)
    else $error("idle result carries a tone");

  // The enable follows the frequency: a rest is never driven.
  a_on_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tone_on == (out_tone_freq_hz != '0))
    else $error("tone enable does not match frequency");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_tone_freq_hz (out_tone_freq_hz),
  .out_tone_on      (out_tone_on),
  .out_busy_res     (out_busy_res)
);
